[rtl/cascaded_one_pole_lowpass_defines.svh]
// ---------------------------------------------------------------------------
// cascaded one-pole lowpass assertion macros
// Shared concurrent assertion forms used by the filter bank top level.
// ---------------------------------------------------------------------------
`ifndef CASCADED_ONE_POLE_LOWPASS_DEFINES_SVH
`define CASCADED_ONE_POLE_LOWPASS_DEFINES_SVH

// same-cycle implication, held off during reset
`define COP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define COP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cop_pkg.sv]
// ---------------------------------------------------------------------------
// cop_pkg
// Field widths and payload types of the cascaded one-pole lowpass bank.
// ---------------------------------------------------------------------------
package cop_pkg;

  // payload field widths
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 16;
  localparam int STREAM_W  = 8;
  localparam int ORDER_W   = 4;

  // stream index splits into filter number (upper) and channel (lower)
  localparam int SLOT_BITS = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [COEF_W-1:0]   coef_t;
  typedef logic        [STREAM_W-1:0] stream_t;
  typedef logic        [ORDER_W-1:0]  order_t;

endpackage

[rtl/cop_if.sv]
// ---------------------------------------------------------------------------
// cop_if
// Valid/ready channels carrying sample beats into and out of the bank.
// ---------------------------------------------------------------------------
interface cop_in_if import cop_pkg::*; ();
  logic    valid;
  logic    ready;
  stream_t stream_index;
  sample_t sample_in;
  coef_t   pole_coef;
  order_t  filter_order;

  modport source (output valid, output stream_index, output sample_in,
                  output pole_coef, output filter_order, input ready);
  modport sink   (input valid, input stream_index, input sample_in,
                  input pole_coef, input filter_order, output ready);
endinterface

interface cop_out_if import cop_pkg::*; ();
  logic    valid;
  logic    ready;
  stream_t stream_tag;
  sample_t sample_out;

  modport source (output valid, output stream_tag, output sample_out, input ready);
  modport sink   (input valid, input stream_tag, input sample_out, output ready);
endinterface

[rtl/cop_state_ram.sv]
// ---------------------------------------------------------------------------
// cop_state_ram
// Pole state store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cop_state_ram import cop_pkg::*; #(
  parameter int DEPTH = 1920,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sample_t       wdata,
  input  logic [AW-1:0] raddr,
  output sample_t       rdata
);

  sample_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cop_pole_mac.sv]
// ---------------------------------------------------------------------------
// cop_pole_mac
// One pole update: y = x + floor(r * (s - x) / 2^16), equal to k*x + r*s.
// ---------------------------------------------------------------------------
module cop_pole_mac import cop_pkg::*; (
  input  sample_t x,
  input  sample_t s,
  input  coef_t   r,
  output sample_t y
);

  logic signed [SAMPLE_W:0]          diff;
  logic signed [SAMPLE_W+COEF_W+1:0] prod;
  logic signed [SAMPLE_W+1:0]        step;
  logic signed [SAMPLE_W+1:0]        sum;

  // distance from input to stored state
  assign diff = (SAMPLE_W+1)'(s) - (SAMPLE_W+1)'(x);

  // single signed multiply by the unsigned coefficient
  assign prod = diff * $signed({1'b0, r});

  // drop the fraction, rounding towards minus infinity
  assign step = $signed(prod[SAMPLE_W+COEF_W+1:COEF_W]);

  // convex combination stays within the sample range
  assign sum = (SAMPLE_W+2)'(x) + step;
  assign y   = $signed(sum[SAMPLE_W-1:0]);

endmodule

[rtl/cascaded_one_pole_lowpass.sv]
// ---------------------------------------------------------------------------
// cascaded_one_pole_lowpass
// Bank of cascaded one-pole lowpass filters with pole states in one memory.
//
//   channel  dir  payload                                          
//   in_ch    in   stream_index, sample_in, pole_coef, filter_order 
//   out_ch   out  stream_tag, sample_out                           
//
// An item passes the idle state, which accepts it and issues the first
// state read, the run state, which updates each pole in turn on the
// shared multiply-add with read-modify-write of the state memory, and
// the hand-off state. Pole states read as zero after reset through one
// valid bit per stream, so no clearing pass is needed. A stalled output
// holds the finished item in the hand-off state and accepts no new item.
// ---------------------------------------------------------------------------
`include "cascaded_one_pole_lowpass_defines.svh"

module cascaded_one_pole_lowpass import cop_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int POLES    = 10,
  parameter int FILTERS  = 12
) (
  input logic   clk,
  input logic   rst,
  cop_in_if.sink    in_ch,
  cop_out_if.source out_ch
);

  localparam int ROWS  = FILTERS * CHANNELS;
  localparam int DEPTH = ROWS * POLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW    = (POLES > 1) ? $clog2(POLES) : 1;
  localparam logic [SLOT_BITS:0] FILT_LIM = (SLOT_BITS+1)'(FILTERS);
  localparam logic [SLOT_BITS:0] CHAN_LIM = (SLOT_BITS+1)'(CHANNELS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t              state;
  logic [ROWS-1:0]     row_valid;
  logic                row_live;
  sample_t             x_acc;
  coef_t               coef;
  order_t              order;
  stream_t             tag;
  logic [RW-1:0]       row;
  logic [AW-1:0]       addr;
  logic [PW-1:0]       pole;
  sample_t             sel_y;
  logic                out_valid;
  stream_t             out_tag;
  sample_t             out_sample;

  logic [SLOT_BITS-1:0] in_filt;
  logic [SLOT_BITS-1:0] in_chan;
  logic                 in_range;
  logic [RW-1:0]        in_row;
  logic [AW-1:0]        in_base;
  logic                 accept;
  logic [AW-1:0]        ram_raddr;
  logic                 ram_we;
  sample_t              ram_rdata;
  sample_t              s_cur;
  sample_t              y;
  logic                 last;
  logic                 hit;

  // stream decode and row base address
  assign in_filt  = in_ch.stream_index[2*SLOT_BITS-1:SLOT_BITS];
  assign in_chan  = in_ch.stream_index[SLOT_BITS-1:0];
  assign in_range = ({1'b0, in_filt} < FILT_LIM) && ({1'b0, in_chan} < CHAN_LIM);
  assign in_row   = RW'(in_filt * CHANNELS + in_chan);
  assign in_base  = AW'(in_row * POLES);
  assign accept   = in_ch.valid & in_ch.ready;

  // read one pole ahead of the one being updated
  assign ram_raddr = (state == ST_IDLE) ? in_base : AW'(addr + 1'b1);
  assign ram_we    = (state == ST_RUN);

  cop_state_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (y),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // untouched streams read as zero state
  assign s_cur = row_live ? ram_rdata : '0;

  cop_pole_mac u_mac (
    .x (x_acc),
    .s (s_cur),
    .r (coef),
    .y (y)
  );

  assign last = (pole == PW'(POLES - 1));
  assign hit  = (((ORDER_W+1)'(pole) + (ORDER_W+1)'(1)) == {1'b0, order});

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      // the hand-off state reloads the output register itself
      if (out_valid && out_ch.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x_acc    <= in_ch.sample_in;
            coef     <= in_ch.pole_coef;
            order    <= in_ch.filter_order;
            tag      <= in_ch.stream_index;
            row      <= in_row;
            addr     <= in_base;
            pole     <= '0;
            sel_y    <= '0;
            row_live <= row_valid[in_row];
            state    <= in_range ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          x_acc <= y;
          addr  <= AW'(addr + 1'b1);
          pole  <= PW'(pole + 1'b1);
          if (hit) begin
            sel_y <= y;
          end
          if (last) begin
            row_valid[row] <= 1'b1;
            state          <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_tag    <= tag;
            out_sample <= sel_y;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.stream_tag = out_tag;
  assign out_ch.sample_out = out_sample;

  // checks
  `COP_ASSERT_IMP(a_pole_bound, clk, rst, (state == ST_RUN),
                  (pole <= PW'(POLES - 1)), "pole count past last stage")
  `COP_ASSERT_NXT(a_skip_range, clk, rst, (accept && !in_range),
                  (state == ST_DONE), "out-of-range stream entered the pole loop")
  `COP_ASSERT_NXT(a_done_hold, clk, rst,
                  (state == ST_DONE && out_valid && !out_ch.ready),
                  (state == ST_DONE && $stable(sel_y)),
                  "finished result lost while output stalled")

endmodule
